// ===== design/srf_pkg.sv =====
// Package for the sensor reading ASCII framer.
// Holds payload and command types, frame byte kinds, character constants
// and the BCD and hex helper functions. Depends on nothing.
`default_nettype none

package srf_pkg;

  localparam int MAG_W      = 32;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int CONV_STEPS = MAG_W;
  localparam int FRAME_LEN  = 29;
  localparam int CNT_W      = 5;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;

  localparam logic [3:0] KIND_DOLLAR = 4'd0;
  localparam logic [3:0] KIND_SIGN_P = 4'd1;
  localparam logic [3:0] KIND_DIG_P  = 4'd2;
  localparam logic [3:0] KIND_COMMA  = 4'd3;
  localparam logic [3:0] KIND_SIGN_T = 4'd4;
  localparam logic [3:0] KIND_DIG_T  = 4'd5;
  localparam logic [3:0] KIND_STAR   = 4'd6;
  localparam logic [3:0] KIND_HEX_HI = 4'd7;
  localparam logic [3:0] KIND_HEX_LO = 4'd8;
  localparam logic [3:0] KIND_CR     = 4'd9;
  localparam logic [3:0] KIND_LF     = 4'd10;

  typedef struct packed {
    logic signed [31:0] pressure;
    logic signed [31:0] temperature;
  } srf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } srf_out_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       emit;
    logic [3:0] kind;
  } srf_cmd_t;

  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic din);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], din};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'b0000, nib};
    return (nib <= 4'd9) ? (CHAR_ZERO + wide) : (CHAR_UPPER_A + wide - 8'd10);
  endfunction

endpackage

`default_nettype wire

// ===== design/srf_ctrl.sv =====
// Controller of the sensor reading ASCII framer.
// Sequences load, 32 conversion steps and 29 byte emits; uses srf_pkg.
`default_nettype none

module srf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  output srf_pkg::srf_cmd_t    cmd
);
  import srf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [3:0]       kind;

  always_comb begin
    priority if (cnt == 5'd0) begin
      kind = KIND_DOLLAR;
    end else if (cnt == 5'd1) begin
      kind = KIND_SIGN_P;
    end else if (cnt <= 5'd11) begin
      kind = KIND_DIG_P;
    end else if (cnt == 5'd12) begin
      kind = KIND_COMMA;
    end else if (cnt == 5'd13) begin
      kind = KIND_SIGN_T;
    end else if (cnt <= 5'd23) begin
      kind = KIND_DIG_T;
    end else if (cnt == 5'd24) begin
      kind = KIND_STAR;
    end else if (cnt == 5'd25) begin
      kind = KIND_HEX_HI;
    end else if (cnt == 5'd26) begin
      kind = KIND_HEX_LO;
    end else if (cnt == 5'd27) begin
      kind = KIND_CR;
    end else begin
      kind = KIND_LF;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.emit   = 1'b0;
    cmd.kind   = kind;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (cnt == CNT_W'(CONV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = ST_EMIT;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (cnt == CNT_W'(FRAME_LEN - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      default: begin
        cnt_next   = '0;
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// ===== design/srf_datapath.sv =====
// Datapath of the sensor reading ASCII framer.
// Holds magnitudes, BCD shift registers, checksum and the output register;
// driven by srf_ctrl commands, uses srf_pkg.
`default_nettype none

module srf_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire srf_pkg::srf_in_t  reading,
  input  wire srf_pkg::srf_cmd_t cmd,
  output srf_pkg::srf_out_t    result,
  output logic                 strobe
);
  import srf_pkg::*;

  logic [MAG_W-1:0] mag_p;
  logic [MAG_W-1:0] mag_t;
  logic [BCD_W-1:0] bcd_p;
  logic [BCD_W-1:0] bcd_t;
  logic             neg_p;
  logic             neg_t;
  logic [7:0]       sum;
  logic [7:0]       byte_next;
  logic             summed;
  logic [MAG_W-1:0] raw_p;
  logic [MAG_W-1:0] raw_t;

  assign raw_p = $unsigned(reading.pressure);
  assign raw_t = $unsigned(reading.temperature);

  always_comb begin
    summed = 1'b0;
    unique case (cmd.kind)
      KIND_DOLLAR: byte_next = CHAR_DOLLAR;
      KIND_SIGN_P: begin
        byte_next = neg_p ? CHAR_MINUS : CHAR_PLUS;
        summed    = 1'b1;
      end
      KIND_DIG_P: begin
        byte_next = CHAR_ZERO + {4'b0000, bcd_p[BCD_W-1 -: 4]};
        summed    = 1'b1;
      end
      KIND_COMMA: begin
        byte_next = CHAR_COMMA;
        summed    = 1'b1;
      end
      KIND_SIGN_T: begin
        byte_next = neg_t ? CHAR_MINUS : CHAR_PLUS;
        summed    = 1'b1;
      end
      KIND_DIG_T: begin
        byte_next = CHAR_ZERO + {4'b0000, bcd_t[BCD_W-1 -: 4]};
        summed    = 1'b1;
      end
      KIND_STAR:   byte_next = CHAR_STAR;
      KIND_HEX_HI: byte_next = hex_char(sum[7:4]);
      KIND_HEX_LO: byte_next = hex_char(sum[3:0]);
      KIND_CR:     byte_next = CHAR_CR;
      KIND_LF:     byte_next = CHAR_LF;
      default:     byte_next = CHAR_LF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_p <= raw_p[MAG_W-1];
      neg_t <= raw_t[MAG_W-1];
      mag_p <= raw_p[MAG_W-1] ? (MAG_W'(0) - raw_p) : raw_p;
      mag_t <= raw_t[MAG_W-1] ? (MAG_W'(0) - raw_t) : raw_t;
      bcd_p <= '0;
      bcd_t <= '0;
      sum   <= '0;
    end else if (cmd.step) begin
      bcd_p <= dabble_step(bcd_p, mag_p[MAG_W-1]);
      bcd_t <= dabble_step(bcd_t, mag_t[MAG_W-1]);
      mag_p <= {mag_p[MAG_W-2:0], 1'b0};
      mag_t <= {mag_t[MAG_W-2:0], 1'b0};
    end else if (cmd.emit) begin
      if (summed) begin
        sum <= sum + byte_next;
      end
      if (cmd.kind == KIND_DIG_P) begin
        bcd_p <= {bcd_p[BCD_W-5:0], 4'b0000};
      end
      if (cmd.kind == KIND_DIG_T) begin
        bcd_t <= {bcd_t[BCD_W-5:0], 4'b0000};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.out_byte <= byte_next;
      result.last     <= (cmd.kind == KIND_LF);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

endmodule

`default_nettype wire

// ===== design/sensor_reading_ascii_framer.sv =====
// Top level of the sensor reading ASCII framer; instantiates srf_ctrl and
// srf_datapath, uses srf_pkg.
// The first frame byte shows after the binary-to-BCD conversion, then one byte per
// cycle for the rest of the frame. A new start is taken only in idle, so each frame
// runs the 32-step binary-to-BCD shift loop followed by the 29-byte emit sequence.
// Reset: rst (synchronous) returns the controller to idle and drops strobe.
`default_nettype none

module sensor_reading_ascii_framer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire srf_pkg::srf_in_t reading,
  output logic                 busy,
  output logic                 strobe,
  output srf_pkg::srf_out_t    result
);
  import srf_pkg::*;

  srf_cmd_t cmd;

  srf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  srf_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .reading (reading),
    .cmd     (cmd),
    .result  (result),
    .strobe  (strobe)
  );

endmodule

`default_nettype wire

// ===== design/srf_checker.sv =====
// Port-level checker for the sensor reading ASCII framer, with its bind.
// Uses srf_pkg for the result type.
`default_nettype none

module srf_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              strobe,
  input wire srf_pkg::srf_out_t result
);
  import srf_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> (!busy && !strobe))
    else $error("not idle after reset");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after start transfer");

  a_mid_frame_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |-> busy)
    else $error("frame byte shown while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |=> !strobe)
    else $error("byte after frame end");

  a_frame_opens: assert property (@(posedge clk) disable iff (rst)
    $rose(strobe) |-> (result.out_byte == CHAR_DOLLAR))
    else $error("frame does not open with dollar");

endmodule

bind sensor_reading_ascii_framer srf_checker u_srf_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

`default_nettype wire

// ===== sim/sensor_reading_ascii_framer_test.sv =====
`timescale 1ns / 100ps
// Testbench for sensor_reading_ascii_framer: sends reading pairs over start/busy
// and checks every framed byte against a local frame builder or a golden frame table.
// Depends on srf_pkg and the framer RTL.

module sensor_reading_ascii_framer_test;
  import srf_pkg::*;

  localparam int DIRECTED_ROWS = 20;
  localparam int RANDOM_ITEMS  = 110;
  localparam int MAX_REPORTS   = 10;
  localparam int DRAIN_CYCLES  = 80;
  localparam int FRAME_BITS    = FRAME_LEN * 8;

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  srf_in_t  reading;
  logic     busy;
  logic     strobe;
  srf_out_t result;

  srf_out_t pending_bytes[$];
  srf_out_t want_byte;
  int       mismatch_count = 0;
  int       calm_left = 0;

  logic [31:0] row_pressure [DIRECTED_ROWS] = '{
    32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
    32'hFFFF_FFFF, 32'd1, 32'd9, 32'd10, 32'd999999999,
    32'd1000000000, 32'd1999999999, 32'h8000_0001, 32'd1234567890, 32'hAAAA_AAAA,
    32'hFFFF_0000, 32'd100, 32'd0, 32'hDEAD_BEEF, 32'd65535
  };
  logic [31:0] row_temperature [DIRECTED_ROWS] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'd1, 32'hFFFF_FFFF, -32'sd9, -32'sd10, -32'sd999999999,
    -32'sd1000000000, 32'd2000000000, 32'h7FFF_FFFE, -32'sd987654321, 32'h5555_5555,
    32'h0000_FFFF, 32'd0, -32'sd100, 32'h0BAD_F00D, -32'sd65536
  };
  bit row_typed [DIRECTED_ROWS] = '{
    1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };
  logic [FRAME_BITS-1:0] row_golden [DIRECTED_ROWS] = '{
    {"$+0000000000,+0000000000*42", CHAR_CR, CHAR_LF},
    {"$+2147483647,-2147483648*A1", CHAR_CR, CHAR_LF},
    {"$-2147483648,+2147483647*A1", CHAR_CR, CHAR_LF},
    {"$+2147483647,+2147483647*9E", CHAR_CR, CHAR_LF},
    {"$-2147483648,-2147483648*A4", CHAR_CR, CHAR_LF},
    {"$-0000000001,+0000000001*46", CHAR_CR, CHAR_LF},
    '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0
  };

  sensor_reading_ascii_framer i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .reading(reading),
    .busy(busy),
    .strobe(strobe),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CHAR_ZERO + {4'd0, nib};
    end
    return CHAR_UPPER_A + {4'd0, nib} - 8'd10;
  endfunction

  function automatic logic [87:0] decimal_field(input logic [31:0] value);
    logic [31:0] mag;
    logic [31:0] weight;
    logic [31:0] digit;
    logic [87:0] text;
    text[87:80] = value[31] ? CHAR_MINUS : CHAR_PLUS;
    mag = value[31] ? (~value + 32'd1) : value;
    weight = 32'd1000000000;
    for (int i = 0; i < 10; i++) begin
      digit = mag / weight;
      mag = mag - digit * weight;
      text[79 - 8*i -: 8] = CHAR_ZERO + digit[7:0];
      weight = weight / 32'd10;
    end
    return text;
  endfunction

  function automatic logic [7:0] field_sum(input logic [87:0] text);
    logic [7:0] acc;
    acc = 8'd0;
    for (int i = 0; i < 11; i++) begin
      acc = acc + text[8*i +: 8];
    end
    return acc;
  endfunction

  function automatic logic [FRAME_BITS-1:0] frame_text(input srf_in_t pair);
    logic [87:0] p_text;
    logic [87:0] t_text;
    logic [7:0]  check;
    p_text = decimal_field(pair.pressure);
    t_text = decimal_field(pair.temperature);
    check = field_sum(p_text) + field_sum(t_text) + CHAR_COMMA;
    return {CHAR_DOLLAR, p_text, CHAR_COMMA, t_text, CHAR_STAR,
            ascii_hex(check[7:4]), ascii_hex(check[3:0]), CHAR_CR, CHAR_LF};
  endfunction

  function automatic logic [31:0] draw_reading();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: begin
        v = $urandom_range(0, 99);
      end
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h8000_0001;
          default: v = 32'h0000_0000;
        endcase
      end
      2: begin
        v = 32'd1;
        repeat ($urandom_range(0, 9)) v = v * 32'd10;
        v = v + $urandom_range(0, 2) - 32'd1;
      end
      default: begin
        v = $urandom;
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      v = -v;
    end
    return v;
  endfunction

  task automatic report(input string what, input srf_out_t want, input srf_out_t got);
    if (mismatch_count < MAX_REPORTS) begin
      $display("%0t %s: expected byte %h last %b, got byte %h last %b",
               $realtime, what, want.out_byte, want.last, got.out_byte, got.last);
    end
    mismatch_count++;
  endtask

  // Transfer one reading pair; expected frame goes in on the accepting edge.
  task automatic send_reading(input srf_in_t pair, input logic [FRAME_BITS-1:0] frame);
    int       gap;
    bit       after_idle;
    srf_out_t entry;
    if (calm_left == 0 && $urandom_range(0, 5) == 0) begin
      calm_left = $urandom_range(6, 14);
    end
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
      after_idle = 1'b0;
    end else begin
      gap = $urandom_range(0, 12);
      after_idle = $urandom_range(0, 1);
    end
    if (gap != 0 || after_idle) begin
      start <= 1'b0;
      if (after_idle) begin
        do @(posedge clk); while (busy);
      end
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    reading <= pair;
    do @(posedge clk); while (busy);
    for (int k = 0; k < FRAME_LEN; k++) begin
      entry.out_byte = frame[FRAME_BITS - 1 - 8*k -: 8];
      entry.last = (k == FRAME_LEN - 1);
      pending_bytes.push_back(entry);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_bytes.size() == 0) begin
        want_byte = '0;
        report("unexpected byte", want_byte, result);
      end else begin
        want_byte = pending_bytes.pop_front();
        if (result !== want_byte) begin
          report("byte mismatch", want_byte, result);
        end
      end
    end
  end

  initial begin
    srf_in_t pair;
    start <= 1'b0;
    reading <= '0;
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      pair.pressure = row_pressure[r];
      pair.temperature = row_temperature[r];
      send_reading(pair, row_typed[r] ? row_golden[r] : frame_text(pair));
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pair.pressure = draw_reading();
      pair.temperature = draw_reading();
      send_reading(pair, frame_text(pair));
    end
    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[sensor_reading_ascii_framer] OK");
    end else begin
      $display("[sensor_reading_ascii_framer] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[sensor_reading_ascii_framer] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
design/srf_pkg.sv
design/srf_ctrl.sv
design/srf_datapath.sv
design/sensor_reading_ascii_framer.sv
design/srf_checker.sv
sim/sensor_reading_ascii_framer_test.sv
